// ===== rtl/core/rfid_manchester_frame_receiver_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the 125 kHz Manchester frame receiver
// Each check samples on the rising edge of clk and is disabled while arst_n
// is low. Defining NO_ASSERTIONS turns every check into nothing.
// ----------------------------------------------------------------------------
`ifndef RFID_MANCHESTER_FRAME_RECEIVER_TOP_ASSERT_SVH
`define RFID_MANCHESTER_FRAME_RECEIVER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// The condition holds at every clock edge.
`define RMFR_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// The antecedent implies the consequent in the same cycle.
`define RMFR_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define RMFR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define RMFR_ASSERT_ALWAYS(label, cond, msg)
`define RMFR_ASSERT_IMPLY(label, ante, cons, msg)
`define RMFR_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== rtl/core/rmfr_pkg.sv =====
// ----------------------------------------------------------------------------
// rmfr_pkg
// Types, codes and the frame check shared by the Manchester frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package rmfr_pkg;

	// Input word modes.
	localparam logic [1:0] MODE_START = 2'd0;
	localparam logic [1:0] MODE_EDGE  = 2'd1;
	localparam logic [1:0] MODE_TICK  = 2'd2;

	// Result status codes.
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_HEADER  = 2'd1;
	localparam logic [1:0] STATUS_PARITY  = 2'd2;
	localparam logic [1:0] STATUS_TIMEOUT = 2'd3;

	// Configuration register indexes.
	localparam logic CFG_WIDE_THRESHOLD = 1'b0;
	localparam logic CFG_TIMEOUT_TICKS  = 1'b1;

	// Reset values of the configuration registers.
	localparam logic [15:0] WIDE_THRESHOLD_RESET = 16'd40;
	localparam logic [7:0]  TIMEOUT_TICKS_RESET  = 8'd60;

	// Frame layout.
	localparam logic [6:0] FRAME_BITS  = 7'd64;
	localparam int         HEADER_ONES = 9;
	localparam int         ROWS        = 10;
	localparam logic [7:0] TICKS_MAX   = 8'hFF;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] capture_time;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [39:0] card_id;
		logic [63:0] raw_frame;
		logic [6:0]  bits_received;
	} out_word_t;

	// Classified command passed from the front part to the back part.
	typedef struct packed {
		logic [1:0] kind;
		logic       wide;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [39:0] card_id;
	} check_t;

	// Header and row parity check of a complete frame, first bit in bit 63.
	function automatic check_t frame_check(input logic [63:0] frame);
		check_t     res;
		logic       head_bad;
		logic       par_bad;
		logic [3:0] nib;
		logic [39:0] id;
		head_bad = 1'b0;
		par_bad  = 1'b0;
		id       = '0;
		for (int i = 0; i < HEADER_ONES; i++) begin
			if (!frame[63 - i])
				head_bad = 1'b1;
		end
		for (int r = 0; r < ROWS; r++) begin
			for (int k = 0; k < 4; k++)
				nib[3 - k] = frame[63 - (HEADER_ONES + 5 * r + k)];
			if (frame[63 - (HEADER_ONES + 5 * r + 4)] != ^nib)
				par_bad = 1'b1;
			id = {id[35:0], nib};
		end
		if (head_bad)
			res.status = STATUS_HEADER;
		else if (par_bad)
			res.status = STATUS_PARITY;
		else
			res.status = STATUS_OK;
		res.card_id = (res.status == STATUS_OK) ? id : '0;
		return res;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rfid_manchester_frame_receiver_top.sv =====
// ----------------------------------------------------------------------------
// rfid_manchester_frame_receiver_top
// Manchester frame receiver for 125 kHz read-only cards: start, edge and tick
// words in, one status word with card ID and raw frame out per finished or timed-out read attempt.
// ----------------------------------------------------------------------------
// The block takes one input word per clock while full is low; only a finished
// frame or a timeout yields a result word. An accepted word is registered in
// the command queue, and the back part writes any result it yields into the
// result queue, from which it shows on the result ports. The rate is set by
// the back part, which applies one command per cycle to the receiver state
// while the result queue is not full (one subtract and compare for the edge
// interval in the front, one shift and the frame check in the back). Two small
// queues decouple the sides: full rises only when the command queue holds
// CMD_DEPTH words, and the back part pauses only while the result queue is
// full. A start word arms the receiver; edge and tick words are ignored while
// idle. Configuration writes are always ready and take effect at once.
`default_nettype none

module rfid_manchester_frame_receiver_top #(
	parameter int CAPTURE_BITS = 16,
	parameter int CMD_DEPTH    = 2,
	parameter int RES_DEPTH    = 2
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire rmfr_pkg::in_word_t  item,
	output logic                     full,
	input  wire logic                pop,
	output rmfr_pkg::out_word_t      result,
	output logic                     empty,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic                cfg_index,
	input  wire logic [15:0]         cfg_data
);

	localparam int CmdW = $bits(rmfr_pkg::cmd_t);
	localparam int ResW = $bits(rmfr_pkg::out_word_t);

	logic [15:0]         wide_threshold_q;
	logic [7:0]          timeout_ticks_q;
	logic                cmd_push;
	rmfr_pkg::cmd_t      cmd_in;
	logic                cmd_full;
	logic [CmdW-1:0]     cmd_head;
	logic                cmd_empty;
	logic                cmd_pop;
	logic                res_push;
	rmfr_pkg::out_word_t res_in;
	logic                res_full;
	logic [ResW-1:0]     res_head;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_threshold_q <= rmfr_pkg::WIDE_THRESHOLD_RESET;
			timeout_ticks_q  <= rmfr_pkg::TIMEOUT_TICKS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rmfr_pkg::CFG_WIDE_THRESHOLD: wide_threshold_q <= cfg_data;
				rmfr_pkg::CFG_TIMEOUT_TICKS:  timeout_ticks_q  <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// Front part: accept and classify.
	rmfr_front #(
		.CAPTURE_BITS(CAPTURE_BITS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.item           (item),
		.full           (full),
		.wide_threshold (wide_threshold_q),
		.cmd_push       (cmd_push),
		.cmd            (cmd_in),
		.cmd_full       (cmd_full)
	);

	// Command queue between the two parts.
	rmfr_fifo #(
		.WIDTH(CmdW),
		.DEPTH(CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.din    (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.dout   (cmd_head),
		.empty  (cmd_empty)
	);

	// Back part: receiver state and frame check.
	rmfr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (!cmd_empty),
		.cmd           (rmfr_pkg::cmd_t'(cmd_head)),
		.cmd_pop       (cmd_pop),
		.timeout_ticks (timeout_ticks_q),
		.res_full      (res_full),
		.res_push      (res_push),
		.res           (res_in)
	);

	// Result queue facing the consumer.
	rmfr_fifo #(
		.WIDTH(ResW),
		.DEPTH(RES_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res_in),
		.full   (res_full),
		.pop    (pop),
		.dout   (res_head),
		.empty  (empty)
	);

	assign result = rmfr_pkg::out_word_t'(res_head);

endmodule

`default_nettype wire

// ===== rtl/core/rmfr_fifo.sv =====
// ----------------------------------------------------------------------------
// rmfr_fifo
// Small register queue with full and empty flags; the head word is shown
// on dout while empty is low.
// ----------------------------------------------------------------------------
`default_nettype none

module rmfr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] din,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      dout,
	output logic                  empty
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PtrW-1:0]  wptr_q;
	logic [PtrW-1:0]  rptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CntW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rptr_q];

	// Storage; payload needs no reset.
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wptr_q] <= din;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wptr_q <= (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (do_pop)
				rptr_q <= (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/rmfr_front.sv =====
// ----------------------------------------------------------------------------
// rmfr_front
// Accepts input words, measures the interval between demodulator edges and
// classifies each word into a command for the back part.
// ----------------------------------------------------------------------------
`default_nettype none

module rmfr_front #(
	parameter int CAPTURE_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire rmfr_pkg::in_word_t item,
	output logic                   full,
	input  wire logic [15:0]       wide_threshold,
	output logic                   cmd_push,
	output rmfr_pkg::cmd_t         cmd,
	input  wire logic              cmd_full
);

	// Only the capture bits that both the port and the timer carry count.
	localparam int CapW = (CAPTURE_BITS < 16) ? CAPTURE_BITS : 16;

	logic [CapW-1:0] prev_capture_q;
	logic [CapW-1:0] now;
	logic [CapW-1:0] interval;
	logic            accept;

	assign full     = cmd_full;
	assign accept   = push && !cmd_full;
	assign now      = item.capture_time[CapW-1:0];
	assign interval = now - prev_capture_q;

	// Unused mode codes are dropped here and never reach the back part.
	assign cmd_push = accept && (item.mode == rmfr_pkg::MODE_START ||
		item.mode == rmfr_pkg::MODE_EDGE || item.mode == rmfr_pkg::MODE_TICK);
	assign cmd.kind = item.mode;
	assign cmd.wide = (16'(interval) > wide_threshold);

	// Previous capture; a start clears it so the first interval counts from zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_capture_q <= '0;
		end else if (accept) begin
			if (item.mode == rmfr_pkg::MODE_START)
				prev_capture_q <= '0;
			else if (item.mode == rmfr_pkg::MODE_EDGE)
				prev_capture_q <= now;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/rmfr_back.sv =====
// ----------------------------------------------------------------------------
// rmfr_back
// Carries out classified commands: Manchester bit recovery, frame assembly,
// frame check and timeout, and writes result words.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rfid_manchester_frame_receiver_top_assert.svh"

module rmfr_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cmd_valid,
	input  wire rmfr_pkg::cmd_t  cmd,
	output logic                 cmd_pop,
	input  wire logic [7:0]      timeout_ticks,
	input  wire logic            res_full,
	output logic                 res_push,
	output rmfr_pkg::out_word_t  res
);

	logic        bit_level_q, bit_level_d;
	logic        save_next_q, save_next_d;
	logic [6:0]  bit_count_q, bit_count_d;
	logic [63:0] frame_shift_q, frame_shift_d;
	logic [7:0]  elapsed_q, elapsed_d;
	logic        receiving_q, receiving_d;
	logic        frame_done;
	logic        timed_out;
	logic        store_en;
	logic        bit_val;
	rmfr_pkg::check_t chk;

	// A command is taken only when a result word can be stored.
	assign cmd_pop  = cmd_valid && !res_full;
	assign store_en = cmd.wide || save_next_q;
	assign bit_val  = cmd.wide ? !bit_level_q : bit_level_q;

	// Next state for the command at the head of the queue.
	always_comb begin
		bit_level_d   = bit_level_q;
		save_next_d   = save_next_q;
		bit_count_d   = bit_count_q;
		frame_shift_d = frame_shift_q;
		elapsed_d     = elapsed_q;
		receiving_d   = receiving_q;
		frame_done    = 1'b0;
		timed_out     = 1'b0;
		if (cmd_pop) begin
			unique case (cmd.kind)
				rmfr_pkg::MODE_START: begin
					bit_level_d   = 1'b0;
					save_next_d   = 1'b1;
					bit_count_d   = '0;
					frame_shift_d = '0;
					elapsed_d     = '0;
					receiving_d   = 1'b1;
				end
				rmfr_pkg::MODE_EDGE: begin
					if (receiving_q) begin
						// A wide interval flips the level and restarts the save toggle.
						bit_level_d = bit_val;
						save_next_d = cmd.wide ? 1'b1 : !save_next_q;
						if (store_en && bit_count_q < rmfr_pkg::FRAME_BITS) begin
							frame_shift_d = {frame_shift_q[62:0], bit_val};
							bit_count_d   = bit_count_q + 7'd1;
						end
						if (bit_count_d >= rmfr_pkg::FRAME_BITS) begin
							receiving_d = 1'b0;
							frame_done  = 1'b1;
						end
					end
				end
				rmfr_pkg::MODE_TICK: begin
					if (receiving_q) begin
						if (elapsed_q != rmfr_pkg::TICKS_MAX)
							elapsed_d = elapsed_q + 8'd1;
						if (elapsed_d >= timeout_ticks) begin
							receiving_d = 1'b0;
							timed_out   = 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign chk = rmfr_pkg::frame_check(frame_shift_d);

	// Result word for a finished frame or a timeout.
	always_comb begin
		res_push          = frame_done || timed_out;
		res.status        = frame_done ? chk.status : rmfr_pkg::STATUS_TIMEOUT;
		res.card_id       = frame_done ? chk.card_id : '0;
		res.raw_frame     = frame_shift_d;
		res.bits_received = bit_count_d;
	end

	// Receiver state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_level_q   <= 1'b0;
			save_next_q   <= 1'b1;
			bit_count_q   <= '0;
			frame_shift_q <= '0;
			elapsed_q     <= '0;
			receiving_q   <= 1'b0;
		end else begin
			bit_level_q   <= bit_level_d;
			save_next_q   <= save_next_d;
			bit_count_q   <= bit_count_d;
			frame_shift_q <= frame_shift_d;
			elapsed_q     <= elapsed_d;
			receiving_q   <= receiving_d;
		end
	end

	// The frame never grows past its length.
	`RMFR_ASSERT_ALWAYS(a_count_bound, bit_count_q <= rmfr_pkg::FRAME_BITS, "bit count past frame")
	// Results come only from an attempt in progress.
	`RMFR_ASSERT_IMPLY(a_result_needs_rx, res_push, receiving_q, "result while idle")
	// A result ends the attempt.
	`RMFR_ASSERT_NEXT(a_result_ends_rx, res_push, !receiving_q, "still receiving after result")
	// A narrow edge with the save toggle clear stores nothing.
	`RMFR_ASSERT_NEXT(a_skip_edge, cmd_pop && cmd.kind == rmfr_pkg::MODE_EDGE && !cmd.wide && !save_next_q && receiving_q, $stable(bit_count_q), "skipped edge stored a bit")

endmodule

`default_nettype wire
